### sv/kmrb_pkg.sv
// Shared types and constants of the key matrix report builder.
package kmrb_pkg;

  localparam int DEF_ROWS     = 3;
  localparam int DEF_COLS     = 4;
  localparam int DEF_MAX_KEYS = 6;

  localparam int IN_COLS    = 4;
  localparam int SLOT_COUNT = 6;
  localparam int CODE_W     = 8;
  localparam int FILL_W     = 3;

  localparam logic [CODE_W-1:0] BASE_RESET = 8'd104;

  typedef enum logic [1:0] {
    ACT_REPORT  = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_WAKEUP  = 2'd2
  } action_t;

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } lane_t;

  typedef struct packed {
    logic [FILL_W-1:0]                 count;
    logic [SLOT_COUNT-1:0][CODE_W-1:0] slots;
  } scan_t;

endpackage

### sv/kmrb_if.sv
// Item channels of the key matrix report builder.
interface kmrb_in_if import kmrb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IN_COLS-1:0] column_bits;
  logic               last_row;
  logic               host_suspended;

  modport source (output valid, column_bits, last_row, host_suspended, input ready);
  modport sink (input valid, column_bits, last_row, host_suspended, output ready);
endinterface

interface kmrb_out_if import kmrb_pkg::*; ();
  logic              valid;
  logic              ready;
  action_t           action;
  logic [CODE_W-1:0] key_slot_0;
  logic [CODE_W-1:0] key_slot_1;
  logic [CODE_W-1:0] key_slot_2;
  logic [CODE_W-1:0] key_slot_3;
  logic [CODE_W-1:0] key_slot_4;
  logic [CODE_W-1:0] key_slot_5;
  logic [FILL_W-1:0] pressed_count;

  modport source (output valid, action, key_slot_0, key_slot_1, key_slot_2, key_slot_3,
                  key_slot_4, key_slot_5, pressed_count, input ready);
  modport sink (input valid, action, key_slot_0, key_slot_1, key_slot_2, key_slot_3,
                key_slot_4, key_slot_5, pressed_count, output ready);
endinterface

### sv/kmrb_lane.sv
// One column lane: key detection and keycode for its column of the current row.
module kmrb_lane import kmrb_pkg::*; #(
  parameter int LANE = 0,
  parameter int COLS = DEF_COLS
) (
  input  logic              col_bit,
  input  logic              row_ok,
  input  logic [CODE_W-1:0] row_base,
  output lane_t             lane
);

  localparam bit ENABLED = (LANE < COLS);

  always_comb begin
    lane.hit  = ENABLED && col_bit && row_ok;
    lane.code = row_base + CODE_W'(LANE);
  end

endmodule

### sv/kmrb_merge.sv
// Merging stage: priority placement of lane hits into the six key slots.
module kmrb_merge import kmrb_pkg::*; #(
  parameter int MAX_KEYS = DEF_MAX_KEYS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                last_row,
  input  lane_t [IN_COLS-1:0] lanes,
  output scan_t               scan
);

  logic [FILL_W-1:0]                 fill;
  logic [FILL_W-1:0]                 fill_next;
  logic [SLOT_COUNT-1:0][CODE_W-1:0] codes;
  logic [SLOT_COUNT-1:0][CODE_W-1:0] codes_next;

  always_comb begin
    fill_next  = fill;
    codes_next = codes;
    for (int c = 0; c < IN_COLS; c++) begin
      if (lanes[c].hit && (fill_next < FILL_W'(MAX_KEYS))) begin
        codes_next[fill_next] = lanes[c].code;
        fill_next             = fill_next + 1'b1;
      end
    end
  end

  always_comb begin
    scan.count = fill_next;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      scan.slots[j] = (FILL_W'(j) < fill_next) ? codes_next[j] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= last_row ? '0 : fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      codes <= codes_next;
    end
  end

endmodule

### sv/key_matrix_report_builder.sv
// Top level of the key matrix report builder.
//
// item_in carries the column bits of one matrix row per item, rows in scan
// order, with last_row on the final row and the host suspend state. Each
// of four column lanes checks its key and forms its keycode (base code plus
// row * COLS + column); the merging stage places hits into up to MAX_KEYS
// slots in row-major order. Rows past ROWS add no keys.
// On the last row at most one item leaves on report_out: a wakeup when keys
// are down and the host is suspended, a report when keys are down otherwise,
// a release (empty slots) when no keys are down after a report, else nothing.
// cfg_we / cfg_wdata write the base keycode (104 after reset).
// The result is registered and shows in the cycle after the last row
// is accepted. One row item per cycle, no bubbles, unless report_out stalls.
// A stalled report_out holds its item; item_in takes a new row whenever the
// output register is empty or being emptied in the same cycle.
// Reset clears the scan, the report flag and the output valid, and restores
// the base keycode.
module key_matrix_report_builder import kmrb_pkg::*; #(
  parameter int ROWS     = DEF_ROWS,
  parameter int COLS     = DEF_COLS,
  parameter int MAX_KEYS = DEF_MAX_KEYS
) (
  input  logic              clk,
  input  logic              rst,
  kmrb_in_if.sink           item_in,
  kmrb_out_if.source        report_out,
  input  logic              cfg_we,
  input  logic [CODE_W-1:0] cfg_wdata
);

  localparam int ROW_W = $clog2(ROWS + 1);

  logic [CODE_W-1:0]                 key_base;
  logic [ROW_W-1:0]                  row_cnt;
  logic [CODE_W-1:0]                 row_off;
  logic                              report_active;
  logic                              out_valid;
  action_t                           out_action;
  logic [SLOT_COUNT-1:0][CODE_W-1:0] out_slots;
  logic [FILL_W-1:0]                 out_count;

  logic                accept;
  logic                row_ok;
  logic [CODE_W-1:0]   row_base;
  lane_t [IN_COLS-1:0] lanes;
  scan_t               scan;
  logic                has_keys;
  logic                emit;

  assign item_in.ready = !out_valid || report_out.ready;
  assign accept        = item_in.valid && item_in.ready;
  assign row_ok        = (row_cnt < ROW_W'(ROWS));
  assign row_base      = key_base + row_off;
  assign has_keys      = (scan.count != '0);
  assign emit          = item_in.last_row && (has_keys || report_active);

  for (genvar c = 0; c < IN_COLS; c++) begin : g_lane
    kmrb_lane #(
      .LANE (c),
      .COLS (COLS)
    ) u_lane (
      .col_bit  (item_in.column_bits[c]),
      .row_ok   (row_ok),
      .row_base (row_base),
      .lane     (lanes[c])
    );
  end

  kmrb_merge #(
    .MAX_KEYS (MAX_KEYS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .last_row (item_in.last_row),
    .lanes    (lanes),
    .scan     (scan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_base <= BASE_RESET;
    end else if (cfg_we) begin
      key_base <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      row_off <= '0;
    end else if (accept) begin
      if (item_in.last_row) begin
        row_cnt <= '0;
        row_off <= '0;
      end else if (row_ok) begin
        row_cnt <= row_cnt + 1'b1;
        row_off <= row_off + CODE_W'(COLS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_active <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept && emit) begin
        out_valid <= 1'b1;
        if (has_keys) begin
          if (!item_in.host_suspended) begin
            report_active <= 1'b1;
          end
        end else begin
          report_active <= 1'b0;
        end
      end else if (report_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      if (has_keys) begin
        out_action <= item_in.host_suspended ? ACT_WAKEUP : ACT_REPORT;
        out_slots  <= scan.slots;
        out_count  <= scan.count;
      end else begin
        out_action <= ACT_RELEASE;
        out_slots  <= '0;
        out_count  <= '0;
      end
    end
  end

  assign report_out.valid         = out_valid;
  assign report_out.action        = out_action;
  assign report_out.key_slot_0    = out_slots[0];
  assign report_out.key_slot_1    = out_slots[1];
  assign report_out.key_slot_2    = out_slots[2];
  assign report_out.key_slot_3    = out_slots[3];
  assign report_out.key_slot_4    = out_slots[4];
  assign report_out.key_slot_5    = out_slots[5];
  assign report_out.pressed_count = out_count;

`ifndef SYNTHESIS
  a_release_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_action == ACT_RELEASE)) |-> (out_count == '0))
    else $error("release item carries keys");

  a_keys_present: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_action != ACT_RELEASE)) |-> (out_count != '0))
    else $error("report or wakeup item without keys");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_count <= FILL_W'(MAX_KEYS)))
    else $error("key count above limit");

  a_report_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_action == ACT_REPORT)) |-> report_active)
    else $error("report pending with flag clear");
`endif

endmodule
